/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/oaidu_pkg.sv */
package oaidu_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W = 7;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_APPLY
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  new_value;
  } oaidu_in_t;

  typedef struct packed {
    status_t                   status;
    logic [CNT_W-1:0]          fill_count;
    logic [IDX_W-1:0]          affected_index;
  } oaidu_out_t;

  typedef struct packed {
    logic                      cmp_en;
    logic signed [DATA_W-1:0]  key;
    logic                      apply;
    cmd_t                      cmd;
    logic [IDX_W-1:0]          idx;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  wdata;
  } oaidu_cell_ctl_t;

endpackage

/* rtl/core/oaidu_cell.sv */
module oaidu_cell
  import oaidu_pkg::*;
(
  input  logic                      clk,
  input  logic [IDX_W-1:0]          cell_idx,
  input  oaidu_cell_ctl_t           ctl,
  input  logic signed [DATA_W-1:0]  lower_q,
  input  logic signed [DATA_W-1:0]  upper_q,
  output logic signed [DATA_W-1:0]  q,
  output logic                      match
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     match_r;
  logic                     match_nxt;
  logic [CNT_W-1:0]         pos_ext;
  logic [CNT_W-1:0]         pos_p1;

  assign pos_ext = CNT_W'(cell_idx);
  assign pos_p1  = pos_ext + CNT_W'(1);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.apply) begin
      case (ctl.cmd)
        CMD_APPEND, CMD_UPDATE: begin
          if (cell_idx == ctl.idx) entry_nxt = ctl.wdata;
        end
        CMD_INSERT: begin
          if (cell_idx == ctl.idx) begin
            entry_nxt = ctl.wdata;
          end else if (cell_idx > ctl.idx && pos_ext <= ctl.count) begin
            entry_nxt = lower_q;
          end
        end
        CMD_DELETE: begin
          if (cell_idx >= ctl.idx && pos_p1 < ctl.count) entry_nxt = upper_q;
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) match_nxt = (entry_r == ctl.key) && (pos_ext < ctl.count);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign q     = entry_r;
  assign match = match_r;

endmodule

/* rtl/core/ordered_array_insert_delete_update_unit.sv */
// Append and insert go from accept through S_APPLY to the result strobe; delete and
// update pass through S_FIND first, the search for the highest matching cell.
// A new item is accepted in the cycle the result strobe is shown; no new item is
// accepted while the last one is still in progress.
// Synchronous active-low reset empties the array; entry contents are not cleared.
// The result is shown for one cycle and the receiver cannot stall it.
`include "assert_macros.svh"

module ordered_array_insert_delete_update_unit
  import oaidu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  oaidu_in_t   in_item,
  output logic        out_valid,
  output oaidu_out_t  out_item
);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  oaidu_out_t                out_item_r, out_item_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  status_t                   status_r, status_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [DATA_W-1:0]  val_r, val_nxt;
  logic signed [DATA_W-1:0]  nval_r, nval_nxt;

  logic                      accept;
  oaidu_cell_ctl_t           ctl;
  logic signed [DATA_W-1:0]  cell_q [DEPTH];
  logic [DEPTH-1:0]          match_vec;
  logic [DEPTH-1:0]          top_hit;
  logic [IDX_W-1:0]          hit_idx;
  logic                      hit_found;
  logic [POS_W-1:0]          pos_m1;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pos_m1 = in_item.position - POS_W'(1);

  always_comb begin
    ctl.cmp_en = accept;
    ctl.key    = in_item.value;
    ctl.apply  = (state_r == S_APPLY) && (status_r == ST_OK);
    ctl.cmd    = cmd_r;
    ctl.idx    = idx_r;
    ctl.count  = count_r;
    ctl.wdata  = (cmd_r == CMD_UPDATE) ? nval_r : val_r;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower_w;
    logic signed [DATA_W-1:0] upper_w;
    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = cell_q[g+1];
    end
    oaidu_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (ctl),
      .lower_q  (lower_w),
      .upper_q  (upper_w),
      .q        (cell_q[g]),
      .match    (match_vec[g])
    );
  end

  // The highest matching cell is the one with no match above it.
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < DEPTH; k++) begin
      top_hit[k] = match_vec[k] && !(|(match_vec >> (k + 1)));
    end
    for (int k = 0; k < DEPTH; k++) begin
      hit_idx = hit_idx | (top_hit[k] ? IDX_W'(k) : IDX_W'(0));
    end
    hit_found = |match_vec;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    nval_nxt      = nval_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_item.cmd;
          val_nxt    = in_item.value;
          nval_nxt   = in_item.new_value;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          state_nxt  = S_APPLY;
          case (in_item.cmd)
            CMD_APPEND: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt = count_r[IDX_W-1:0];
              end
            end
            CMD_INSERT: begin
              if (in_item.position == '0 || in_item.position > POS_W'(count_r)) begin
                status_nxt = ST_BADPOS;
              end else if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt = pos_m1[IDX_W-1:0];
              end
            end
            CMD_DELETE, CMD_UPDATE: state_nxt = S_FIND;
            default: state_nxt = S_APPLY;
          endcase
        end
      end
      S_FIND: begin
        if (hit_found) begin
          status_nxt = ST_OK;
          idx_nxt    = hit_idx;
        end else begin
          status_nxt = ST_NOTFOUND;
          idx_nxt    = '0;
        end
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (status_r == ST_OK) begin
          case (cmd_r)
            CMD_APPEND, CMD_INSERT: count_nxt = count_r + CNT_W'(1);
            CMD_DELETE:             count_nxt = count_r - CNT_W'(1);
            default:                count_nxt = count_r;
          endcase
        end
        out_valid_nxt               = 1'b1;
        out_item_nxt.status         = status_r;
        out_item_nxt.fill_count     = count_nxt;
        out_item_nxt.affected_index = idx_r;
        state_nxt                   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    nval_r     <= nval_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_CLK(a_count_range, count_r <= CNT_W'(DEPTH), "Fill count exceeds the array depth.")
  `ASSERT_CLK(a_strobe_single, out_valid_r |=> !out_valid_r, "Result strobe held for two cycles.")
  `ASSERT_CLK(a_accept_busy, accept |=> busy, "Block not busy after accepting an item.")
  `ASSERT_IMPLY(a_err_idx_zero, out_valid_r && out_item_r.status != ST_OK, out_item_r.affected_index == '0, "Failed command reports a nonzero index.")
  `ASSERT_IMPLY(a_apply_valid, ctl.apply && cmd_r == CMD_DELETE, count_r != '0, "Delete applied to an empty array.")

endmodule
